// ===== hw/rtl/mqsjs_pkg.sv =====
// Shared types and constants for the multi-queue shortest-job scheduler.
// Used by the controller, datapath and top level; no dependencies.
package mqsjs_pkg;

  localparam int CmdW = 2;
  localparam logic [1:0] CMD_ENQ     = 2'd0;
  localparam logic [1:0] CMD_SERVE   = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [2:0] ST_ENQUEUED  = 3'd0;
  localparam logic [2:0] ST_SERVED    = 3'd1;
  localparam logic [2:0] ST_BAD_QUEUE = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  localparam logic [31:0] CLOCK_MAX = 32'hFFFF_FFFF;
  localparam logic [15:0] BASE_RESET = 16'd20;
  localparam logic [15:0] UNIT_RESET = 16'd10;

  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_UNIT = 1'b1;

  // Controller commands to the datapath.
  typedef struct packed {
    logic capture;    // latch the incoming item
    logic enq_write;  // write the job and bump the tail
    logic scan_clr;   // reset the head scan
    logic scan_step;  // evaluate one queue head
    logic finish;     // add the size*unit product and commit the serve
    logic restart;    // clear the clock
    logic out_load;   // load the output register
  } dp_cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       scan_done;
  } dp_stat_t;

endpackage

// ===== hw/rtl/multi_queue_shortest_job_scheduler.sv =====
// Multi-queue shortest-job-first scheduler, top level.
// Enqueue: states DECODE and OUT after accept; serve: DECODE, SCAN, FINISH and OUT
// (one queue head read from the job store RAM per cycle in SCAN, then a
// multiply-add). Restart passes through DECODE only and gives no result. One item is in work at a time.
// rst_n is synchronous, active low: queues empty, clock zero, registers 20/10.
// The job store is not cleared; only written entries are ever used.
module multi_queue_shortest_job_scheduler #(
  parameter int NumQueues  = 12,
  parameter int QueueDepth = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] command, [5:2] queue_number, [37:6] arrival_time, [53:38] job_size
  input  logic [55:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] status, [6:3] served_queue, [38:7] finish_time,
  // [70:39] served_arrival, [86:71] served_size
  output logic [87:0]  out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data
);
  import mqsjs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller waits in its output state while an older result is held.
  mqsjs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .out_busy(out_tvalid && !out_tready), .stat(stat), .cmd(cmd)
  );

  mqsjs_dp #(.NumQueues(NumQueues), .QueueDepth(QueueDepth)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_data(in_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_tready(out_tready), .out_tvalid(out_tvalid), .out_tdata(out_tdata)
  );
endmodule

// ===== hw/rtl/mqsjs_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module mqsjs_ram #(
  parameter int Width = 48,
  parameter int Depth = 192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/mqsjs_ctrl.sv =====
// Controller state machine of the scheduler.
// Depends on mqsjs_pkg.
module mqsjs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_busy,
  input  mqsjs_pkg::dp_stat_t stat,
  output mqsjs_pkg::dp_cmd_t  cmd
);
  import mqsjs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_SCAN   = 5'b00100,
    S_FINISH = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.cmd)
          CMD_ENQ: state_nxt = S_OUT;
          CMD_SERVE: begin
            cmd.scan_clr = 1'b1;
            state_nxt = S_SCAN;
          end
          CMD_RESTART: begin
            cmd.restart = 1'b1;
            state_nxt = S_IDLE;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          cmd.enq_write = (stat.cmd == CMD_ENQ);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_cap_next: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == S_DECODE) else $error("capture lost");
  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> state_r == S_OUT) else $error("finish not followed by out");
`endif
endmodule

// ===== hw/rtl/mqsjs_dp.sv =====
// Datapath: queue pointers, job store, head scan, clock and output register.
// Depends on mqsjs_pkg and mqsjs_ram.
module mqsjs_dp #(
  parameter int NumQueues  = 12,
  parameter int QueueDepth = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mqsjs_pkg::dp_cmd_t  cmd,
  output mqsjs_pkg::dp_stat_t stat,
  input  logic [55:0]         in_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [87:0]         out_tdata
);
  import mqsjs_pkg::*;

  localparam int QW = (NumQueues > 1) ? $clog2(NumQueues) : 1;
  localparam int PW = $clog2(QueueDepth);
  localparam int CW = $clog2(QueueDepth + 1);
  localparam int AW = $clog2(NumQueues * QueueDepth);
  localparam int QNW = $clog2(NumQueues + 1);

  logic [PW-1:0] head_r [NumQueues];
  logic [PW-1:0] tail_r [NumQueues];
  logic [CW-1:0] fill_r [NumQueues];
  logic [31:0] clock_r;
  logic [15:0] base_r, unit_r;

  logic [1:0]  c_cmd_r;
  logic [3:0]  c_qn_r;
  logic [31:0] c_arr_r;
  logic [15:0] c_size_r;

  // Scan state: issue address index, and result index registered behind it in step with the RAM read data.
  logic [QNW-1:0] iss_r;
  logic           rd_v_r;
  logic [QW-1:0]  rd_q_r;
  logic           best_v_r;
  logic [QW-1:0]  best_q_r;
  logic [31:0]    best_arr_r;
  logic [15:0]    best_size_r;
  logic [47:0]    prod_r;
  logic [32:0]    start_r;

  logic [47:0] rd_data;
  logic [AW-1:0] raddr, waddr;
  logic [QW-1:0] eq;
  logic qn_ok, q_full;
  logic [87:0] out_nxt;

  assign qn_ok = (c_qn_r != 4'd0) && ({{(32-4){1'b0}}, c_qn_r} <= 32'(NumQueues));
  assign eq    = QW'(c_qn_r - 4'd1);
  assign q_full = qn_ok && (fill_r[eq] == CW'(QueueDepth));
  assign waddr = AW'(eq) * AW'(QueueDepth) + AW'(tail_r[eq]);
  assign raddr = AW'(iss_r) * AW'(QueueDepth) + AW'(head_r[QW'(iss_r)]);

  mqsjs_ram #(.Width(48), .Depth(NumQueues * QueueDepth)) u_store (
    .clk(clk), .we(cmd.enq_write && qn_ok && !q_full), .waddr(waddr),
    .wdata({c_size_r, c_arr_r}), .raddr(raddr), .rdata(rd_data)
  );

  assign stat.cmd = c_cmd_r;
  assign stat.scan_done = (iss_r == QNW'(NumQueues)) && !rd_v_r;

  // Head comparison: arrived heads beat waiting ones.
  logic a_in, b_in, beats;
  logic [31:0] a_arr; logic [15:0] a_sz;
  always_comb begin
    a_arr = rd_data[31:0];
    a_sz  = rd_data[47:32];
    a_in  = a_arr <= clock_r;
    b_in  = best_arr_r <= clock_r;
    if (a_in != b_in)  beats = a_in;
    else if (a_in && a_sz != best_size_r) beats = a_sz < best_size_r;
    else beats = a_arr < best_arr_r;
  end

  logic [33:0] fin;
  always_comb fin = {1'b0, start_r} + 34'(base_r) + 34'(prod_r);

  // Result item as it will be loaded into the output register.
  always_comb begin
    out_nxt = '0;
    if (c_cmd_r == CMD_ENQ) begin
      out_nxt[2:0] = !qn_ok ? ST_BAD_QUEUE : (q_full ? ST_FULL : ST_ENQUEUED);
    end else if (!best_v_r) begin
      out_nxt[2:0] = ST_EMPTY;
    end else begin
      out_nxt[2:0]   = ST_SERVED;
      out_nxt[6:3]   = 4'(best_q_r) + 4'd1;
      out_nxt[38:7]  = clock_r;
      out_nxt[70:39] = best_arr_r;
      out_nxt[86:71] = best_size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      c_cmd_r  <= in_data[1:0];
      c_qn_r   <= in_data[5:2];
      c_arr_r  <= in_data[37:6];
      c_size_r <= in_data[53:38];
    end
    if (cmd.scan_clr) begin
      iss_r <= '0;
      rd_v_r <= 1'b0;
      best_v_r <= 1'b0;
    end else if (cmd.scan_step) begin
      rd_v_r <= (iss_r != QNW'(NumQueues)) && (fill_r[QW'(iss_r)] != '0);
      if (iss_r != QNW'(NumQueues)) begin
        rd_q_r <= QW'(iss_r);
        iss_r  <= iss_r + 1'b1;
      end
      if (rd_v_r && (!best_v_r || beats)) begin
        best_v_r <= 1'b1;
        best_q_r <= rd_q_r;
        best_arr_r <= a_arr;
        best_size_r <= a_sz;
      end
    end
    if (cmd.scan_step && stat.scan_done) begin
      prod_r  <= 48'(best_size_r) * 48'(unit_r);
      start_r <= {1'b0, (best_arr_r > clock_r) ? best_arr_r : clock_r};
    end
    if (!rst_n) begin
      out_tvalid <= 1'b0;
      clock_r <= '0;
      base_r <= BASE_RESET;
      unit_r <= UNIT_RESET;
      for (int i = 0; i < NumQueues; i++) begin
        head_r[i] <= '0; tail_r[i] <= '0; fill_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BASE) base_r <= cfg_data;
        else                       unit_r <= cfg_data;
      end
      if (cmd.out_load)     out_tvalid <= 1'b1;
      else if (out_tready)  out_tvalid <= 1'b0;
      if (cmd.restart) clock_r <= '0;
      if (cmd.finish && best_v_r) begin
        clock_r <= (fin > 34'(CLOCK_MAX)) ? CLOCK_MAX : fin[31:0];
        head_r[best_q_r] <= (head_r[best_q_r] == PW'(QueueDepth - 1)) ? '0
                            : head_r[best_q_r] + 1'b1;
        fill_r[best_q_r] <= fill_r[best_q_r] - 1'b1;
      end
      if (cmd.enq_write && qn_ok && !q_full) begin
        tail_r[eq] <= (tail_r[eq] == PW'(QueueDepth - 1)) ? '0 : tail_r[eq] + 1'b1;
        fill_r[eq] <= fill_r[eq] + 1'b1;
      end
    end
    if (cmd.out_load) out_tdata <= out_nxt;
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enq_write && qn_ok |-> fill_r[eq] <= CW'(QueueDepth)) else $error("overfill");
  a_clk_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.restart |=> clock_r == '0) else $error("clock not cleared");
  a_served_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && best_v_r |-> fill_r[best_q_r] != '0) else $error("serve of empty queue");
`endif
endmodule
